@@ src/hex_record_checksum_checker_macros.svh @@
// Assertion macros for the top-level file, which checks its own behaviour.
`ifndef HEX_RECORD_CHECKSUM_CHECKER_MACROS_SVH
`define HEX_RECORD_CHECKSUM_CHECKER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define HRC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that stays active through reset.
`define HRC_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hrc_pkg.sv @@
`timescale 1ns / 1ps

package hrc_pkg;

    // Class of one character as seen by the accumulator.
    typedef enum logic [1:0] {
        TOK_DIGIT,
        TOK_BAD,
        TOK_SKIP
    } t_tok_class;

    typedef struct packed {
        t_tok_class cls;
        logic [3:0] digit;
        logic       eol;
        logic       short_line;
    } t_token;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] checksum;
        logic [7:0] byte_count;
    } t_result;

    localparam logic [1:0] ST_MATCH     = 2'd0;
    localparam logic [1:0] ST_MISMATCH  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic       FMT_INTEL_HEX = 1'b0;
    localparam logic       FMT_SRECORD   = 1'b1;

    localparam logic [1:0] SREC_TYPE_CHARS = 2'd2;

endpackage

@@ src/hrc_fifo.sv @@
`timescale 1ns / 1ps

module hrc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/hrc_front.sv @@
`timescale 1ns / 1ps

module hrc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_record_format,
    input  logic           i_accept,
    input  logic [7:0]     i_char_code,
    input  logic           i_end_of_line,
    output hrc_pkg::t_token o_token
);

    import hrc_pkg::*;

    logic       r_line_start, n_line_start;
    logic [1:0] r_skip_left, n_skip_left;
    logic [1:0] eff_skip;
    logic       is_num;
    logic       is_hex_letter;

    assign is_num        = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
    assign is_hex_letter = (i_char_code >= 8'h41) && (i_char_code <= 8'h46);

    // The type skip is loaded from the format in force at the first character.
    assign eff_skip = r_line_start
                    ? ((i_record_format == FMT_SRECORD) ? SREC_TYPE_CHARS : 2'd0)
                    : r_skip_left;

    always_comb begin
        n_skip_left      = eff_skip;
        o_token.cls      = TOK_BAD;
        o_token.digit    = 4'd0;
        o_token.eol      = i_end_of_line;
        if (eff_skip != 2'd0) begin
            o_token.cls = TOK_SKIP;
            n_skip_left = eff_skip - 2'd1;
        end else if (is_num) begin
            o_token.cls   = TOK_DIGIT;
            o_token.digit = i_char_code[3:0];
        end else if (is_hex_letter) begin
            // 'A' is 0x41, so the low nibble plus nine gives 10 to 15.
            o_token.cls   = TOK_DIGIT;
            o_token.digit = i_char_code[3:0] + 4'd9;
        end
        o_token.short_line = i_end_of_line && (n_skip_left != 2'd0);
        n_line_start       = i_end_of_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_start <= 1'b1;
            r_skip_left  <= 2'd0;
        end else if (i_accept) begin
            r_line_start <= n_line_start;
            r_skip_left  <= n_skip_left;
        end
    end

endmodule

@@ src/hrc_back.sv @@
`timescale 1ns / 1ps

module hrc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_record_format,
    input  hrc_pkg::t_token i_token,
    input  logic            i_tok_valid,
    output logic            o_tok_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output hrc_pkg::t_result o_result
);

    import hrc_pkg::*;

    logic [7:0] r_sum, n_sum;
    logic [3:0] r_pending, n_pending;
    logic       r_phase, n_phase;
    logic       r_bad, n_bad;
    logic [7:0] r_seen, n_seen;
    logic [7:0] r_last, n_last;
    logic [7:0] expect_sum;

    // A line end needs room in the result queue; other items go straight through.
    assign o_tok_pop  = i_tok_valid && (!i_token.eol || !i_res_full);
    assign o_res_push = o_tok_pop && i_token.eol;

    always_comb begin
        n_sum     = r_sum;
        n_pending = r_pending;
        n_phase   = r_phase;
        n_bad     = r_bad;
        n_seen    = r_seen;
        n_last    = r_last;
        unique case (i_token.cls)
            TOK_SKIP: begin
            end
            TOK_DIGIT: begin
                if (!r_phase) begin
                    n_pending = i_token.digit;
                    n_phase   = 1'b1;
                end else begin
                    // The previous byte joins the sum only once a newer byte arrives.
                    if (r_seen != 8'd0) begin
                        n_sum = r_sum + r_last;
                    end
                    n_last    = {r_pending, i_token.digit};
                    n_seen    = (r_seen == 8'hFF) ? r_seen : r_seen + 8'd1;
                    n_phase   = 1'b0;
                    n_pending = 4'd0;
                end
            end
            default: begin
                n_bad = 1'b1;
            end
        endcase

        expect_sum = (i_record_format == FMT_SRECORD) ? ~n_sum : (8'd0 - n_sum);

        o_result.checksum   = expect_sum;
        o_result.byte_count = n_seen;
        if (n_bad || n_phase || (n_seen == 8'd0) || i_token.short_line) begin
            o_result.status = ST_MALFORMED;
        end else if (expect_sum == n_last) begin
            o_result.status = ST_MATCH;
        end else begin
            o_result.status = ST_MISMATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_tok_pop && i_token.eol)) begin
            r_sum     <= 8'd0;
            r_pending <= 4'd0;
            r_phase   <= 1'b0;
            r_bad     <= 1'b0;
            r_seen    <= 8'd0;
            r_last    <= 8'd0;
        end else if (o_tok_pop) begin
            r_sum     <= n_sum;
            r_pending <= n_pending;
            r_phase   <= n_phase;
            r_bad     <= n_bad;
            r_seen    <= n_seen;
            r_last    <= n_last;
        end
    end

endmodule

@@ src/hex_record_checksum_checker.sv @@
`timescale 1ns / 1ps
// The result of a line is pushed into the result queue when the accumulator takes the line's last item,
// and it reaches the output ports once the results queued before it have been popped.
// Throughput: one item per cycle while the queues have room, set by the single byte add in the accumulator stage.
// Two short queues decouple the character classifier, the accumulator and the result port.
// Reset is synchronous and active low; it empties both queues, starts a new line and
// selects the Intel HEX format. No clearing pass is needed.

`include "hex_record_checksum_checker_macros.svh"

module hex_record_checksum_checker #(
    parameter int TOKEN_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_line,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_status,
    output logic [7:0] o_computed_checksum,
    output logic [7:0] o_byte_count,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    import hrc_pkg::*;

    logic    r_record_format;
    logic    in_accept;
    t_token  front_token;
    t_token  back_token;
    logic    tok_empty;
    logic    tok_pop;
    logic    res_full;
    logic    res_push;
    t_result back_result;
    t_result out_result;

    assign in_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_format <= FMT_INTEL_HEX;
        end else if (i_cfg_we) begin
            r_record_format <= i_cfg_wdata;
        end
    end

    hrc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_record_format (r_record_format),
        .i_accept        (in_accept),
        .i_char_code     (i_char_code),
        .i_end_of_line   (i_end_of_line),
        .o_token         (front_token)
    );

    hrc_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (TOKEN_DEPTH)
    ) u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_token),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_data  (back_token),
        .o_empty (tok_empty)
    );

    hrc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_record_format (r_record_format),
        .i_token         (back_token),
        .i_tok_valid     (!tok_empty),
        .o_tok_pop       (tok_pop),
        .i_res_full      (res_full),
        .o_res_push      (res_push),
        .o_result        (back_result)
    );

    hrc_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_result),
        .o_empty (empty)
    );

    assign o_status            = out_result.status;
    assign o_computed_checksum = out_result.checksum;
    assign o_byte_count        = out_result.byte_count;

    `HRC_ASSERT_NEXT(a_reset_no_result, i_clk, !i_rst_n, empty, "result queue not empty after reset")
    `HRC_ASSERT_IMPLIES(a_pop_has_token, i_clk, i_rst_n, tok_pop, !tok_empty, "accumulator took an item from an empty queue")
    `HRC_ASSERT_IMPLIES(a_push_has_room, i_clk, i_rst_n, res_push, !res_full, "result pushed into a full queue")
    `HRC_ASSERT_IMPLIES(a_match_has_bytes, i_clk, i_rst_n, !empty && (o_status == ST_MATCH), o_byte_count != 8'd0, "matching line reported without bytes")

endmodule
